@@ src/ordered_list_store_with_match_ops_macros.svh @@
// assertion macros for the ordered list store
`ifndef ORDERED_LIST_STORE_WITH_MATCH_OPS_MACROS_SVH
`define ORDERED_LIST_STORE_WITH_MATCH_OPS_MACROS_SVH
`ifndef ASSERT_OFF
`define OLSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("olsm assertion failed");
`define OLSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("olsm assertion failed");
`else
`define OLSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define OLSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ src/olsm_pkg.sv @@
// shared constants, types and helpers of the ordered list store
package olsm_pkg;

    localparam int CAPACITY      = 64;
    localparam int DATA_WIDTH    = 32;
    localparam int IDX_W         = $clog2(CAPACITY);
    localparam int CNT_W         = $clog2(CAPACITY + 1);
    localparam int OPCODE_W      = 2;
    localparam int VALUE_W       = 32;
    localparam int COUNT_FIELD_W = 7;

    localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_FRONT  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_COUNT  = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd3;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [VALUE_W-1:0]  value;
    } request_t;

    typedef struct packed {
        logic [COUNT_FIELD_W-1:0] match_count;
        logic                     found;
        logic [COUNT_FIELD_W-1:0] entries_held;
        logic                     empty_res;
        logic                     status;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
    } stat_t;

    // circular index add, both operands below CAPACITY
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (IDX_W + 1)'(CAPACITY))
        begin
            sum = sum - (IDX_W + 1)'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

@@ src/olsm_ctrl.sv @@
// controller state machine of the ordered list store
`include "ordered_list_store_with_match_ops_macros.svh"

module olsm_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  olsm_pkg::stat_t stat,
    output olsm_pkg::cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `OLSM_ASSERT_NEXT(a_start_scans, clk, rst_n, start && !busy, state_reg == ST_SCAN)
    `OLSM_ASSERT_NEXT(a_scan_ends, clk, rst_n, (state_reg == ST_SCAN) && stat.scan_done,
                      state_reg == ST_FINISH)

endmodule

@@ src/olsm_dp.sv @@
// datapath of the ordered list store: entry memory, scan pointers, result register
`include "ordered_list_store_with_match_ops_macros.svh"

module olsm_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  olsm_pkg::cmd_t     cmd,
    input  olsm_pkg::request_t request,
    output olsm_pkg::stat_t    stat,
    output logic               done,
    output olsm_pkg::result_t  result
);

    logic [olsm_pkg::DATA_WIDTH-1:0] store_reg [olsm_pkg::CAPACITY];
    logic [olsm_pkg::DATA_WIDTH-1:0] rdata_reg;

    logic [olsm_pkg::DATA_WIDTH-1:0] value_reg;
    logic [olsm_pkg::OPCODE_W-1:0]   opcode_reg;

    logic [olsm_pkg::CNT_W-1:0] count_reg, count_next;
    logic [olsm_pkg::IDX_W-1:0] front_reg, front_next;
    logic [olsm_pkg::CNT_W-1:0] rd_reg, rd_next;
    logic [olsm_pkg::CNT_W-1:0] wr_reg, wr_next;
    logic [olsm_pkg::CNT_W-1:0] match_reg, match_next;
    logic                       rvalid_reg;
    logic                       done_reg;
    olsm_pkg::result_t          result_reg, result_next;

    logic                            read_issue;
    logic [olsm_pkg::IDX_W-1:0]      raddr;
    logic                            proc;
    logic                            hit;
    logic                            keep;
    logic                            full;
    logic                            is_insert;
    logic [olsm_pkg::IDX_W-1:0]      new_front;
    logic                            we;
    logic [olsm_pkg::IDX_W-1:0]      waddr;
    logic [olsm_pkg::DATA_WIDTH-1:0] wdata;
    logic                            status_bit;

    assign read_issue = cmd.step && (rd_reg < count_reg);
    assign raddr      = olsm_pkg::ring_add(front_reg, rd_reg[olsm_pkg::IDX_W-1:0]);
    assign proc       = cmd.step && rvalid_reg;
    assign hit        = (rdata_reg == value_reg);
    // survivors of a remove are packed down toward the front
    assign keep       = proc && !hit && (opcode_reg == olsm_pkg::OP_REMOVE);
    assign full       = (count_reg == olsm_pkg::CNT_W'(olsm_pkg::CAPACITY));
    assign is_insert  = (opcode_reg == olsm_pkg::OP_APPEND) ||
                        (opcode_reg == olsm_pkg::OP_FRONT);
    assign new_front  = (front_reg == '0) ? olsm_pkg::IDX_W'(olsm_pkg::CAPACITY - 1)
                                          : front_reg - 1'b1;

    assign stat.scan_done = (rd_reg == count_reg) && !rvalid_reg;

    always_comb
    begin
        we    = 1'b0;
        waddr = olsm_pkg::ring_add(front_reg, wr_reg[olsm_pkg::IDX_W-1:0]);
        wdata = rdata_reg;
        if (keep)
        begin
            we = 1'b1;
        end
        else if (cmd.finish && is_insert && !full)
        begin
            we    = 1'b1;
            wdata = value_reg;
            if (opcode_reg == olsm_pkg::OP_APPEND)
            begin
                waddr = olsm_pkg::ring_add(front_reg, count_reg[olsm_pkg::IDX_W-1:0]);
            end
            else
            begin
                waddr = new_front;
            end
        end
    end

    always_comb
    begin
        rd_next    = rd_reg;
        wr_next    = wr_reg;
        match_next = match_reg;
        if (cmd.load)
        begin
            rd_next    = '0;
            wr_next    = '0;
            match_next = '0;
        end
        else
        begin
            if (read_issue)
            begin
                rd_next = rd_reg + 1'b1;
            end
            if (keep)
            begin
                wr_next = wr_reg + 1'b1;
            end
            if (proc && hit)
            begin
                match_next = match_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        front_next = front_reg;
        status_bit = olsm_pkg::STATUS_OK;
        if (cmd.finish)
        begin
            if (is_insert)
            begin
                if (full)
                begin
                    status_bit = olsm_pkg::STATUS_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    if (opcode_reg == olsm_pkg::OP_FRONT)
                    begin
                        front_next = new_front;
                    end
                end
            end
            else if (opcode_reg == olsm_pkg::OP_REMOVE)
            begin
                count_next = wr_reg;
            end
        end
        result_next              = '0;
        result_next.match_count  = olsm_pkg::COUNT_FIELD_W'(match_reg);
        result_next.found        = (match_reg != '0);
        result_next.entries_held = olsm_pkg::COUNT_FIELD_W'(count_next);
        result_next.empty_res    = (count_next == '0);
        result_next.status       = status_bit;
    end

    // entry memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        rdata_reg <= store_reg[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg  <= request.value[olsm_pkg::DATA_WIDTH-1:0];
            opcode_reg <= request.opcode;
        end
        if (cmd.finish)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            front_reg  <= '0;
            rd_reg     <= '0;
            wr_reg     <= '0;
            match_reg  <= '0;
            rvalid_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            front_reg  <= front_next;
            rd_reg     <= rd_next;
            wr_reg     <= wr_next;
            match_reg  <= match_next;
            rvalid_reg <= read_issue && !cmd.load;
            done_reg   <= cmd.finish;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    `OLSM_ASSERT_IMP(a_wr_behind_rd, clk, rst_n, 1'b1, wr_reg <= rd_reg)
    `OLSM_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1,
                     count_reg <= olsm_pkg::CNT_W'(olsm_pkg::CAPACITY))
    `OLSM_ASSERT_IMP(a_match_bound, clk, rst_n, 1'b1, match_reg <= rd_reg)

endmodule

@@ src/ordered_list_store_with_match_ops.sv @@
// top level of the ordered list store with match operations
//
//  channel  | ports                 | handshake
//  ---------+-----------------------+----------------------------------
//  request  | request (opcode,value)| taken when start high, busy low
//  result   | result (five fields)  | done high for one cycle, no stall
//
// each request scans every held entry once through the single read port of
// the entry memory: busy stays high for 3 cycles plus the entries held before
// the request (2 when the list is empty, 67 at most)
// done pulses in the first cycle with busy low again
// a new request may be taken in the cycle that done pulses
// reset clears the entry count and front pointer; the memory is not cleared
// the result side cannot stall, so a result is never held back
module ordered_list_store_with_match_ops (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  olsm_pkg::request_t request,
    output logic               done,
    output olsm_pkg::result_t  result
);

    olsm_pkg::cmd_t  cmd;
    olsm_pkg::stat_t stat;

    olsm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    olsm_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .stat    (stat),
        .done    (done),
        .result  (result)
    );

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// testbench for the ordered list store: directed table, then random fill, drain and noise bursts
module tb;

    localparam int HALF_PERIOD     = 6;
    localparam int STALL_LIMIT     = 4000;
    localparam int TARGET_REQUESTS = 600;
    localparam int MAX_GAP         = 80;
    localparam int QUIET_FROM      = 250;
    localparam int QUIET_TO        = 400;
    localparam int PRINT_LIMIT     = 30;
    localparam int DIRECTED_ROWS   = 20;

    typedef struct {
        olsm_pkg::request_t req;
        bit                 typed;
        olsm_pkg::result_t  res;
    } vector_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    olsm_pkg::request_t request;
    logic               done;
    olsm_pkg::result_t  result;

    ordered_list_store_with_match_ops u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .request(request),
        .done   (done),
        .result (result)
    );

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // shadow copy of the list: ring buffer with head pointer and length
    logic [olsm_pkg::DATA_WIDTH-1:0] shadow_ring [olsm_pkg::CAPACITY];
    int unsigned                     shadow_len;
    int unsigned                     shadow_head;

    olsm_pkg::result_t predicted_results [$];
    olsm_pkg::result_t oldest_result;
    int unsigned       mismatch_count;
    int unsigned       requests_sent;
    int unsigned       results_checked;
    int unsigned       full_rejects;
    int unsigned       peak_matches;
    int unsigned       stall_cycles;

    logic [olsm_pkg::VALUE_W-1:0] value_pool [4];
    int unsigned                  pool_size;

    // rows with a typed result can be read off directly; the rest use the shadow list
    vector_row_t directed_rows [DIRECTED_ROWS] = '{
        '{'{olsm_pkg::OP_COUNT,  32'h0000_0000}, 1'b1,
          '{7'd0, 1'b0, 7'd0, 1'b1, olsm_pkg::STATUS_OK}},
        '{'{olsm_pkg::OP_REMOVE, 32'hFFFF_FFFF}, 1'b1,
          '{7'd0, 1'b0, 7'd0, 1'b1, olsm_pkg::STATUS_OK}},
        '{'{olsm_pkg::OP_APPEND, 32'h0000_0000}, 1'b1,
          '{7'd0, 1'b0, 7'd1, 1'b0, olsm_pkg::STATUS_OK}},
        '{'{olsm_pkg::OP_APPEND, 32'hFFFF_FFFF}, 1'b1,
          '{7'd0, 1'b0, 7'd2, 1'b0, olsm_pkg::STATUS_OK}},
        '{'{olsm_pkg::OP_FRONT,  32'hFFFF_FFFF}, 1'b1,
          '{7'd1, 1'b1, 7'd3, 1'b0, olsm_pkg::STATUS_OK}},
        '{'{olsm_pkg::OP_FRONT,  32'h0000_0000}, 1'b1,
          '{7'd1, 1'b1, 7'd4, 1'b0, olsm_pkg::STATUS_OK}},
        '{'{olsm_pkg::OP_COUNT,  32'hFFFF_FFFF}, 1'b1,
          '{7'd2, 1'b1, 7'd4, 1'b0, olsm_pkg::STATUS_OK}},
        '{'{olsm_pkg::OP_APPEND, 32'hAAAA_AAAA}, 1'b0, '0},
        '{'{olsm_pkg::OP_FRONT,  32'h5555_5555}, 1'b0, '0},
        '{'{olsm_pkg::OP_APPEND, 32'h8000_0000}, 1'b0, '0},
        '{'{olsm_pkg::OP_FRONT,  32'h0000_0001}, 1'b0, '0},
        '{'{olsm_pkg::OP_COUNT,  32'h5555_5555}, 1'b0, '0},
        '{'{olsm_pkg::OP_REMOVE, 32'hFFFF_FFFF}, 1'b0, '0},
        '{'{olsm_pkg::OP_REMOVE, 32'h0000_0000}, 1'b0, '0},
        '{'{olsm_pkg::OP_APPEND, 32'h5555_5555}, 1'b0, '0},
        '{'{olsm_pkg::OP_REMOVE, 32'h5555_5555}, 1'b0, '0},
        '{'{olsm_pkg::OP_REMOVE, 32'hAAAA_AAAA}, 1'b0, '0},
        '{'{olsm_pkg::OP_REMOVE, 32'h8000_0000}, 1'b0, '0},
        '{'{olsm_pkg::OP_REMOVE, 32'h0000_0001}, 1'b0, '0},
        '{'{olsm_pkg::OP_COUNT,  32'h0000_0001}, 1'b1,
          '{7'd0, 1'b0, 7'd0, 1'b1, olsm_pkg::STATUS_OK}}
    };

    function automatic olsm_pkg::result_t update_list(olsm_pkg::request_t req);
        logic [olsm_pkg::DATA_WIDTH-1:0] key;
        logic [olsm_pkg::DATA_WIDTH-1:0] entry;
        int unsigned                     hits;
        int unsigned                     kept;
        int unsigned                     i;
        olsm_pkg::result_t               res;
        key  = req.value[olsm_pkg::DATA_WIDTH-1:0];
        hits = 0;
        res  = '0;
        res.status = olsm_pkg::STATUS_OK;
        for (i = 0; i < shadow_len; i++)
        begin
            if (shadow_ring[(shadow_head + i) % olsm_pkg::CAPACITY] == key)
            begin
                hits++;
            end
        end
        case (req.opcode)
            olsm_pkg::OP_APPEND, olsm_pkg::OP_FRONT:
            begin
                if (shadow_len >= olsm_pkg::CAPACITY)
                begin
                    res.status = olsm_pkg::STATUS_FULL;
                end
                else if (req.opcode == olsm_pkg::OP_APPEND)
                begin
                    shadow_ring[(shadow_head + shadow_len) % olsm_pkg::CAPACITY] = key;
                    shadow_len++;
                end
                else
                begin
                    shadow_head = (shadow_head + olsm_pkg::CAPACITY - 1) % olsm_pkg::CAPACITY;
                    shadow_ring[shadow_head] = key;
                    shadow_len++;
                end
            end
            olsm_pkg::OP_REMOVE:
            begin
                // survivors slide toward the head in order
                kept = 0;
                for (i = 0; i < shadow_len; i++)
                begin
                    entry = shadow_ring[(shadow_head + i) % olsm_pkg::CAPACITY];
                    if (entry != key)
                    begin
                        shadow_ring[(shadow_head + kept) % olsm_pkg::CAPACITY] = entry;
                        kept++;
                    end
                end
                shadow_len = kept;
            end
            default:
            begin
            end
        endcase
        res.match_count  = olsm_pkg::COUNT_FIELD_W'(hits);
        res.found        = (hits != 0);
        res.entries_held = olsm_pkg::COUNT_FIELD_W'(shadow_len);
        res.empty_res    = (shadow_len == 0);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
        begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
        begin
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
        end
    endtask

    // called just after a falling edge; returns at the falling edge after acceptance
    task automatic issue_request(input olsm_pkg::request_t req, input bit typed,
                                 input olsm_pkg::result_t typed_res);
        olsm_pkg::result_t predicted;
        start   <= 1'b1;
        request <= req;
        do @(posedge clk); while (busy);
        predicted = update_list(req);
        if (predicted.status == olsm_pkg::STATUS_FULL)
        begin
            full_rejects++;
        end
        if (predicted.match_count > peak_matches)
        begin
            peak_matches = predicted.match_count;
        end
        predicted_results.push_back(typed ? typed_res : predicted);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic sender_gap();
        if (requests_sent >= QUIET_FROM && requests_sent < QUIET_TO)
        begin
            return;
        end
        if ($urandom_range(0, 99) < 11)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(negedge clk);
        end
    endtask

    task automatic hold_until_drained();
        start <= 1'b0;
        do @(negedge clk); while (predicted_results.size() != 0);
    endtask

    task automatic send(input logic [olsm_pkg::OPCODE_W-1:0] op,
                        input logic [olsm_pkg::VALUE_W-1:0] val);
        olsm_pkg::request_t req;
        req.opcode = op;
        req.value  = val;
        issue_request(req, 1'b0, '0);
        sender_gap();
    endtask

    function automatic logic [olsm_pkg::VALUE_W-1:0] pool_value();
        return value_pool[$urandom_range(0, pool_size - 1)];
    endfunction

    function automatic logic [olsm_pkg::VALUE_W-1:0] held_value();
        return shadow_ring[(shadow_head + $urandom_range(0, shadow_len - 1)) % olsm_pkg::CAPACITY];
    endfunction

    function automatic logic [olsm_pkg::VALUE_W-1:0] any_value();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 7);
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [olsm_pkg::OPCODE_W-1:0] insert_op();
        return $urandom_range(0, 1) ? olsm_pkg::OP_APPEND : olsm_pkg::OP_FRONT;
    endfunction

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (predicted_results.size() == 0)
            begin
                report_mismatch("result strobe with no request outstanding");
            end
            else
            begin
                oldest_result = predicted_results.pop_front();
                results_checked++;
                check_field("match_count", result.match_count, oldest_result.match_count);
                check_field("found", result.found, oldest_result.found);
                check_field("entries_held", result.entries_held, oldest_result.entries_held);
                check_field("empty_res", result.empty_res, oldest_result.empty_res);
                check_field("status", result.status, oldest_result.status);
            end
        end
    end

    // progress watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no request or result for %0d cycles", STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned row;
        int unsigned burst;
        int unsigned steps;
        rst_n           = 1'b0;
        start           = 1'b0;
        request         = '0;
        shadow_len      = 0;
        shadow_head     = 0;
        mismatch_count  = 0;
        requests_sent   = 0;
        results_checked = 0;
        full_rejects    = 0;
        peak_matches    = 0;
        stall_cycles    = 0;
        pool_size       = 1;
        for (row = 0; row < olsm_pkg::CAPACITY; row++)
        begin
            shadow_ring[row] = '0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (row = 0; row < DIRECTED_ROWS; row++)
        begin
            issue_request(directed_rows[row].req, directed_rows[row].typed,
                          directed_rows[row].res);
            sender_gap();
        end
        hold_until_drained();

        while (requests_sent < TARGET_REQUESTS)
        begin
            burst = $urandom_range(0, 9);
            pool_size = $urandom_range(1, 4);
            for (row = 0; row < 4; row++)
            begin
                value_pool[row] = any_value();
            end
            if (burst < 4)
            begin
                // fill to capacity, then push against the full store
                while (shadow_len < olsm_pkg::CAPACITY)
                begin
                    if ($urandom_range(0, 9) < 2)
                    begin
                        send(olsm_pkg::OP_COUNT, pool_value());
                    end
                    else
                    begin
                        send(insert_op(), pool_value());
                    end
                end
                repeat ($urandom_range(1, 3)) send(insert_op(), pool_value());
                send(olsm_pkg::OP_COUNT, pool_value());
            end
            else if (burst < 7)
            begin
                // drain mostly by removing values that are actually held
                steps = 0;
                while (shadow_len > 0 && steps < 40)
                begin
                    if ($urandom_range(0, 3) != 0)
                    begin
                        send($urandom_range(0, 4) == 0 ? olsm_pkg::OP_COUNT : olsm_pkg::OP_REMOVE,
                             held_value());
                    end
                    else
                    begin
                        send($urandom_range(0, 1) ? olsm_pkg::OP_COUNT : olsm_pkg::OP_REMOVE,
                             any_value());
                    end
                    steps++;
                end
                if (shadow_len == 0)
                begin
                    send($urandom_range(0, 1) ? olsm_pkg::OP_COUNT : olsm_pkg::OP_REMOVE,
                         any_value());
                end
            end
            else
            begin
                repeat ($urandom_range(10, 30))
                begin
                    send(olsm_pkg::OPCODE_W'($urandom_range(0, 3)),
                         $urandom_range(0, 1) ? pool_value() : any_value());
                end
            end
            if ($urandom_range(0, 3) == 0)
            begin
                hold_until_drained();
            end
        end

        start <= 1'b0;
        while (predicted_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (10) @(posedge clk);

        $display("ran %0d requests over fill, drain and noise bursts; %0d full rejections",
                 requests_sent, full_rejects);
        $display("peak match count %0d, %0d results checked, %0d mismatches",
                 peak_matches, results_checked, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
